>>> rtl/fmps_pkg.sv
// shared types and constants of the process selector
`default_nettype none
package fmps_pkg;
   localparam int SLOTS = 64;
   localparam int SLOT_W = 6;
   localparam int PID_W = 31;
   localparam int TICK_W = 32;

   typedef enum logic [2:0] {
      CMD_PICK = 3'd0, CMD_CREATE = 3'd1, CMD_WSTATE = 3'd2, CMD_SETPRI = 3'd3,
      CMD_BOOST = 3'd4, CMD_WLEVEL = 3'd5, CMD_MLFQ = 3'd6, CMD_FCFS = 3'd7
   } cmd_type;

   localparam logic [2:0] ST_UNUSED = 3'd0;
   localparam logic [2:0] ST_USED = 3'd1;
   localparam logic [2:0] ST_RUNNABLE = 3'd3;
   localparam logic [2:0] ST_RUNNING = 3'd4;
   localparam logic [2:0] ST_LAST = 3'd5;

   localparam logic [2:0] RES_OK = 3'd0;
   localparam logic [2:0] RES_NONE = 3'd1;
   localparam logic [2:0] RES_RANGE = 3'd2;
   localparam logic [2:0] RES_SAME_MODE = 3'd3;
   localparam logic [2:0] RES_FULL = 3'd4;

   localparam logic [1:0] TOP_PRIORITY = 2'd3;
   localparam logic [1:0] LAST_LEVEL = 2'd2;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [SLOT_W-1:0] slot;
      logic [PID_W-1:0]  target_pid;
      logic signed [7:0] value;
      logic [2:0]        new_state;
      logic [TICK_W-1:0] now_tick;
   } req_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] picked_slot;
      logic [PID_W-1:0]  picked_pid;
      logic [1:0]        picked_level;
   } rsp_type;

   // one table entry, all fields
   typedef struct packed {
      logic [2:0]        state;
      logic [PID_W-1:0]  pid;
      logic [1:0]        level;
      logic [1:0]        priority_lvl;
      logic [TICK_W-1:0] arrival;
   } entry_type;
endpackage
`default_nettype wire

>>> rtl/fmps_if.sv
// valid/ready channel interface
`default_nettype none
interface fmps_req_if;
   import fmps_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fmps_rsp_if;
   import fmps_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/fmps_beats.sv
// compare unit used by the pick scan, and the generic table ram
`default_nettype none
module fmps_beats (
   input  wire fmps_pkg::entry_type cand,
   input  wire fmps_pkg::entry_type best,
   input  wire                      mlfq,
   output logic                     win
);
   import fmps_pkg::*;
   // fcfs orders by pid, mlfq by level, priority at last level, then arrival
   always_comb begin
      if (!mlfq) begin
         win = cand.pid < best.pid;
      end else if (cand.level != best.level) begin
         win = cand.level < best.level;
      end else if (best.level == LAST_LEVEL && cand.priority_lvl != best.priority_lvl) begin
         win = cand.priority_lvl > best.priority_lvl;
      end else begin
         win = cand.arrival < best.arrival;
      end
   end
endmodule

// single-port-write ram with registered read
module fmps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire                     clock,
   input  wire                     wr_en,
   input  wire [$clog2(DEPTH)-1:0] wr_addr,
   input  wire [WIDTH-1:0]         wr_data,
   input  wire [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   assign rd_data = rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/fcfs_mlfq_process_selector.sv
// process selector top level: table of task slots and scan sequencer
// pick, create and set priority scan 64 slots through a registered read; a set
//    priority hit adds a write pass over the slots; boost and a mode change sweep
//    64 slots; a repeated mode command and the other commands skip both passes
// one item at a time: ready returns in the cycle after the result is taken
// synchronous reset, then a pass over all 64 slots clears the table (unused, priority 3)
//    with ready low; pid counter 1, fcfs mode
`default_nettype none
module fcfs_mlfq_process_selector (
   input wire clock,
   input wire reset,
   fmps_req_if.sink   req,
   fmps_rsp_if.source rsp
);
   import fmps_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_SCAN = 7'b0000100,
      S_DECIDE = 7'b0001000, S_WRITE = 7'b0010000, S_SWEEP = 7'b0100000,
      S_OUT = 7'b1000000
   } fsm_type;

   // level and arrival are always written together
   typedef struct packed {
      logic [1:0]        level;
      logic [TICK_W-1:0] arrival;
   } sched_type;

   fsm_type            fsm_ff, fsm_in;
   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;
   logic [SLOT_W:0]    idx_ff;
   logic               found_ff;
   logic [SLOT_W-1:0]  best_ff;
   entry_type          bent_ff;
   logic [PID_W-1:0]   pidc_ff;
   logic               mlfq_ff;

   logic [SLOT_W-1:0]  idx;
   logic [SLOT_W-1:0]  rd_slot;
   logic               rd_vld;
   logic               last;
   logic               scan_end;
   logic               prio_ok;
   logic               level_ok;
   entry_type          cur;
   logic               win;
   logic               match;

   logic [SLOT_W-1:0]  wr_addr;
   logic               st_we, pid_we, pri_we, sch_we;
   logic [2:0]         st_wd, st_rd;
   logic [PID_W-1:0]   pid_wd, pid_rd;
   logic [1:0]         pri_wd, pri_rd;
   sched_type          sch_wd, sch_rd;

   assign idx = idx_ff[SLOT_W-1:0];
   assign rd_vld = idx_ff != '0;
   assign rd_slot = SLOT_W'(idx_ff[SLOT_W-1:0] - 1'b1);
   assign last = idx == SLOT_W'(SLOTS - 1);
   assign scan_end = idx_ff[SLOT_W];
   assign prio_ok = req_ff.value >= 8'sd0 && req_ff.value <= 8'sd3;
   assign level_ok = req_ff.value >= 8'sd0 && req_ff.value <= 8'sd2;

   // table rams, all read at the scan index
   fmps_ram #(.WIDTH(3), .DEPTH(SLOTS)) u_state_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(wr_addr), .wr_data(st_wd),
      .rd_addr(idx), .rd_data(st_rd)
   );
   fmps_ram #(.WIDTH(PID_W), .DEPTH(SLOTS)) u_pid_ram (
      .clock(clock), .wr_en(pid_we), .wr_addr(wr_addr), .wr_data(pid_wd),
      .rd_addr(idx), .rd_data(pid_rd)
   );
   fmps_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_prio_ram (
      .clock(clock), .wr_en(pri_we), .wr_addr(wr_addr), .wr_data(pri_wd),
      .rd_addr(idx), .rd_data(pri_rd)
   );
   fmps_ram #(.WIDTH($bits(sched_type)), .DEPTH(SLOTS)) u_sched_ram (
      .clock(clock), .wr_en(sch_we), .wr_addr(wr_addr), .wr_data(sch_wd),
      .rd_addr(idx), .rd_data(sch_rd)
   );

   // entry read in the previous cycle
   always_comb begin
      cur.state = st_rd;
      cur.pid = pid_rd;
      cur.level = sch_rd.level;
      cur.priority_lvl = pri_rd;
      cur.arrival = sch_rd.arrival;
   end

   assign match = cur.state != ST_UNUSED && cur.pid == req_ff.target_pid;

   fmps_beats u_beats (.cand(cur), .best(bent_ff), .mlfq(mlfq_ff), .win(win));

   assign req.ready = fsm_ff == S_IDLE;
   assign rsp.valid = fsm_ff == S_OUT;
   assign rsp.payload = rsp_ff;

   // sequencer
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         S_CLEAR: if (last) fsm_in = S_IDLE;
         S_IDLE: begin
            if (req.valid) begin
               case (req.payload.cmd)
                  CMD_PICK, CMD_CREATE, CMD_SETPRI: fsm_in = S_SCAN;
                  CMD_BOOST: fsm_in = S_SWEEP;
                  CMD_MLFQ: fsm_in = mlfq_ff ? S_DECIDE : S_SWEEP;
                  CMD_FCFS: fsm_in = mlfq_ff ? S_SWEEP : S_DECIDE;
                  default: fsm_in = S_DECIDE;
               endcase
            end
         end
         S_SCAN: if (scan_end) fsm_in = S_DECIDE;
         S_SWEEP: if (last) fsm_in = S_DECIDE;
         S_DECIDE: begin
            if (req_ff.cmd == CMD_SETPRI && found_ff && prio_ok) fsm_in = S_WRITE;
            else fsm_in = S_OUT;
         end
         S_WRITE: if (scan_end) fsm_in = S_OUT;
         S_OUT: if (rsp.ready) fsm_in = S_IDLE;
         default: fsm_in = S_IDLE;
      endcase
   end

   // table write port select
   always_comb begin
      wr_addr = idx;
      st_we = 1'b0;
      pid_we = 1'b0;
      pri_we = 1'b0;
      sch_we = 1'b0;
      st_wd = ST_UNUSED;
      pid_wd = '0;
      pri_wd = TOP_PRIORITY;
      sch_wd = '0;
      case (fsm_ff)
         S_CLEAR: begin
            st_we = 1'b1;
            pid_we = 1'b1;
            pri_we = 1'b1;
            sch_we = 1'b1;
         end
         S_SWEEP: begin
            pri_we = 1'b1;
            sch_we = 1'b1;
            sch_wd.arrival = req_ff.cmd == CMD_BOOST ? req_ff.now_tick : '0;
         end
         S_WRITE: begin
            wr_addr = rd_slot;
            pri_we = rd_vld && match;
            pri_wd = req_ff.value[1:0];
         end
         S_DECIDE: begin
            case (req_ff.cmd)
               CMD_PICK: begin
                  wr_addr = best_ff;
                  st_we = found_ff;
                  st_wd = ST_RUNNING;
               end
               CMD_CREATE: begin
                  wr_addr = best_ff;
                  st_we = found_ff;
                  pid_we = found_ff;
                  pri_we = found_ff;
                  sch_we = found_ff;
                  st_wd = ST_USED;
                  pid_wd = pidc_ff;
                  sch_wd.arrival = req_ff.now_tick;
               end
               CMD_WSTATE: begin
                  wr_addr = req_ff.slot;
                  st_we = req_ff.new_state <= ST_LAST;
                  st_wd = req_ff.new_state;
               end
               CMD_WLEVEL: begin
                  wr_addr = req_ff.slot;
                  sch_we = level_ok;
                  sch_wd.level = req_ff.value[1:0];
                  sch_wd.arrival = req_ff.now_tick;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // result of the item
   always_comb begin
      rsp_in = '0;
      case (req_ff.cmd)
         CMD_PICK: begin
            if (!found_ff) begin
               rsp_in.status = RES_NONE;
            end else begin
               rsp_in.picked_slot = best_ff;
               rsp_in.picked_pid = bent_ff.pid;
               rsp_in.picked_level = bent_ff.level;
            end
         end
         CMD_CREATE: begin
            if (!found_ff) begin
               rsp_in.status = RES_FULL;
            end else begin
               rsp_in.picked_slot = best_ff;
               rsp_in.picked_pid = pidc_ff;
            end
         end
         CMD_SETPRI: begin
            if (!found_ff) rsp_in.status = RES_NONE;
            else if (!prio_ok) rsp_in.status = RES_RANGE;
         end
         CMD_WLEVEL: if (!level_ok) rsp_in.status = RES_RANGE;
         CMD_MLFQ: if (mlfq_ff) rsp_in.status = RES_SAME_MODE;
         CMD_FCFS: if (!mlfq_ff) rsp_in.status = RES_SAME_MODE;
         default: rsp_in.status = RES_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= S_CLEAR;
         idx_ff <= '0;
         pidc_ff <= PID_W'(1);
         mlfq_ff <= 1'b0;
      end else begin
         fsm_ff <= fsm_in;
         case (fsm_ff)
            // clearing pass after reset
            S_CLEAR: idx_ff <= idx_ff + 1'b1;
            // latch the item
            S_IDLE: begin
               req_ff <= req.payload;
               idx_ff <= '0;
               found_ff <= 1'b0;
            end
            // one slot per cycle, picks through the compare unit, read data one slot behind the index
            S_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (rd_vld) begin
                  case (req_ff.cmd)
                     CMD_PICK: begin
                        if (cur.state == ST_RUNNABLE && (!found_ff || win)) begin
                           found_ff <= 1'b1;
                           best_ff <= rd_slot;
                           bent_ff <= cur;
                        end
                     end
                     CMD_CREATE: begin
                        if (cur.state == ST_UNUSED && !found_ff) begin
                           found_ff <= 1'b1;
                           best_ff <= rd_slot;
                        end
                     end
                     default: if (match) found_ff <= 1'b1;
                  endcase
               end
            end
            // requeue every slot
            S_SWEEP: idx_ff <= idx_ff + 1'b1;
            // register the result and update counter and mode
            S_DECIDE: begin
               idx_ff <= '0;
               rsp_ff <= rsp_in;
               if (req_ff.cmd == CMD_CREATE && found_ff) pidc_ff <= pidc_ff + 1'b1;
               if (req_ff.cmd == CMD_MLFQ) mlfq_ff <= 1'b1;
               else if (req_ff.cmd == CMD_FCFS) mlfq_ff <= 1'b0;
            end
            // priority write pass over matching slots
            S_WRITE: idx_ff <= idx_ff + 1'b1;
            default: begin
            end
         endcase
      end
   end

   // a result is only offered after the item's work is done
   a_out_after: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !$past(rsp.valid) |-> $past(fsm_ff == S_DECIDE || fsm_ff == S_WRITE))
      else $error("result without work");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready during result");
   a_pick_none: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == S_DECIDE && req_ff.cmd == CMD_PICK && !found_ff |=> rsp_ff.status == RES_NONE)
      else $error("empty pick status");
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      fsm_ff == S_CLEAR |-> !req.ready) else $error("ready while clearing");
endmodule
`default_nettype wire

>>> tb/sv/fcfs_mlfq_process_selector_chk.sv
// checker: predicts the selector's results and compares them with the output channel
`timescale 1ns / 1ps
`default_nettype none
module fcfs_mlfq_process_selector_chk
   import fmps_pkg::*;
(
   input wire    clock,
   input wire    reset,
   input wire    req_valid,
   input wire    req_ready,
   input wire req_type req_payload,
   input wire    rsp_valid,
   input wire    rsp_ready,
   input wire rsp_type rsp_payload,
   output int    fail_count,
   output int    pending,
   output int    rsp_seen
);
   logic [2:0]        tbl_state [SLOTS];
   logic [PID_W-1:0]  tbl_pid [SLOTS];
   logic [1:0]        tbl_level [SLOTS];
   logic [1:0]        tbl_prio [SLOTS];
   logic [TICK_W-1:0] tbl_arrival [SLOTS];
   logic [PID_W-1:0]  next_pid;
   logic              mlfq_mode;
   rsp_type           expected_rsps [$];

   assign pending = expected_rsps.size();

   // count a mismatch and print one line
   task automatic report(input string what, input longint got, input longint want);
      fail_count++;
      $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
   endtask

   function automatic void requeue(input logic [TICK_W-1:0] tick);
      for (int i = 0; i < SLOTS; i++) begin
         tbl_prio[i] = TOP_PRIORITY;
         tbl_level[i] = 2'd0;
         tbl_arrival[i] = tick;
      end
   endfunction

   // true when slot c should displace the current best b
   function automatic bit displaces(input int c, input int b);
      if (!mlfq_mode) return tbl_pid[c] < tbl_pid[b];
      if (tbl_level[c] != tbl_level[b]) return tbl_level[c] < tbl_level[b];
      if (tbl_level[b] == LAST_LEVEL && tbl_prio[c] != tbl_prio[b])
         return tbl_prio[c] > tbl_prio[b];
      return tbl_arrival[c] < tbl_arrival[b];
   endfunction

   function automatic rsp_type schedule(input req_type r);
      rsp_type o;
      int best;
      bit hit;
      int v;
      o = '0;
      best = -1;
      hit = 0;
      v = r.value;
      case (cmd_type'(r.cmd))
         CMD_PICK: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_state[i] == ST_RUNNABLE && (best < 0 || displaces(i, best))) best = i;
            if (best < 0) o.status = RES_NONE;
            else begin
               tbl_state[best] = ST_RUNNING;
               o.picked_slot = SLOT_W'(best);
               o.picked_pid = tbl_pid[best];
               o.picked_level = tbl_level[best];
            end
         end
         CMD_CREATE: begin
            for (int i = 0; i < SLOTS && best < 0; i++)
               if (tbl_state[i] == ST_UNUSED) best = i;
            if (best < 0) o.status = RES_FULL;
            else begin
               tbl_state[best] = ST_USED;
               tbl_pid[best] = next_pid;
               tbl_prio[best] = TOP_PRIORITY;
               tbl_level[best] = 2'd0;
               tbl_arrival[best] = r.now_tick;
               next_pid = next_pid + 1'b1;
               o.picked_slot = SLOT_W'(best);
               o.picked_pid = tbl_pid[best];
            end
         end
         CMD_WSTATE:
            if (r.new_state <= ST_LAST) tbl_state[r.slot] = r.new_state;
         CMD_SETPRI: begin
            for (int i = 0; i < SLOTS; i++)
               if (tbl_state[i] != ST_UNUSED && tbl_pid[i] == r.target_pid) hit = 1;
            if (!hit) o.status = RES_NONE;
            else if (v < 0 || v > 3) o.status = RES_RANGE;
            else
               for (int i = 0; i < SLOTS; i++)
                  if (tbl_state[i] != ST_UNUSED && tbl_pid[i] == r.target_pid)
                     tbl_prio[i] = v[1:0];
         end
         CMD_BOOST: requeue(r.now_tick);
         CMD_WLEVEL:
            if (v < 0 || v > 2) o.status = RES_RANGE;
            else begin
               tbl_level[r.slot] = v[1:0];
               tbl_arrival[r.slot] = r.now_tick;
            end
         CMD_MLFQ:
            if (mlfq_mode) o.status = RES_SAME_MODE;
            else begin
               mlfq_mode = 1'b1;
               requeue('0);
            end
         default:
            if (!mlfq_mode) o.status = RES_SAME_MODE;
            else begin
               mlfq_mode = 1'b0;
               requeue('0);
            end
      endcase
      return o;
   endfunction

   // predict on each accepted command, compare each accepted result
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            tbl_state[i] = ST_UNUSED;
            tbl_pid[i] = '0;
         end
         requeue('0);
         next_pid = PID_W'(1);
         mlfq_mode = 1'b0;
         expected_rsps.delete();
         fail_count = 0;
         rsp_seen = 0;
      end else begin
         if (req_valid && req_ready) expected_rsps.push_back(schedule(req_payload));
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) report("unexpected item", 1, 0);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.status !== want.status)
                  report("status", rsp_payload.status, want.status);
               if (rsp_payload.picked_slot !== want.picked_slot)
                  report("picked_slot", rsp_payload.picked_slot, want.picked_slot);
               if (rsp_payload.picked_pid !== want.picked_pid)
                  report("picked_pid", rsp_payload.picked_pid, want.picked_pid);
               if (rsp_payload.picked_level !== want.picked_level)
                  report("picked_level", rsp_payload.picked_level, want.picked_level);
            end
         end
      end
   end
endmodule
`default_nettype wire

>>> tb/sv/fcfs_mlfq_process_selector_tb.sv
// testbench top: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module fcfs_mlfq_process_selector_tb;
   import fmps_pkg::*;

   localparam int RANDOM_ITEMS = 1000;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int REQ_BITS = $bits(req_type);

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   int     fail_count;
   int     pending;
   int     rsp_seen;
   longint cycles = 0;
   int     issued = 0;

   fmps_req_if req_ch ();
   fmps_rsp_if rsp_ch ();

   fcfs_mlfq_process_selector u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   fcfs_mlfq_process_selector_chk u_chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_payload(rsp_ch.payload),
      .fail_count(fail_count), .pending(pending), .rsp_seen(rsp_seen)
   );

   always #10 clock = ~clock;

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILURE");
         $finish;
      end
   end

   // result side stalls: ready held low for a random wait, which may be zero, before each item
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic send(input req_type r, input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      issued++;
   endtask

   function automatic req_type cmd_item(input cmd_type c, input int s, input int v,
                                        input int ns, input logic [31:0] tick);
      req_type r;
      r.cmd = c;
      r.slot = SLOT_W'(s);
      r.target_pid = PID_W'($urandom);
      r.value = 8'(v);
      r.new_state = 3'(ns);
      r.now_tick = tick;
      return r;
   endfunction

   // mostly well-formed scheduling traffic with random fields mixed in
   function automatic req_type random_item();
      req_type r;
      int k;
      r = REQ_BITS'({$urandom, $urandom, $urandom});
      k = $urandom_range(0, 99);
      if (k < 20) r.cmd = CMD_PICK;
      else if (k < 38) r.cmd = CMD_CREATE;
      else if (k < 60) begin
         r.cmd = CMD_WSTATE;
         r.new_state = ($urandom_range(0, 2) != 0) ? ST_RUNNABLE : 3'($urandom_range(0, 7));
      end else if (k < 72) begin
         r.cmd = CMD_SETPRI;
         if ($urandom_range(0, 3) != 0) r.target_pid = PID_W'($urandom_range(1, 70));
         if ($urandom_range(0, 2) != 0) r.value = 8'($urandom_range(0, 3));
      end else if (k < 76) r.cmd = CMD_BOOST;
      else if (k < 90) begin
         r.cmd = CMD_WLEVEL;
         if ($urandom_range(0, 3) != 0) r.value = 8'($urandom_range(0, 2));
         if ($urandom_range(0, 1) != 0) r.now_tick = $urandom_range(0, 15);
      end else r.cmd = ($urandom_range(0, 1) != 0) ? CMD_MLFQ : CMD_FCFS;
      return r;
   endfunction

   initial begin
      req_type r;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty pick, modes, range errors, fill table to full
      send(cmd_item(CMD_PICK, 0, 0, 0, 0), 0);
      send(cmd_item(CMD_FCFS, 0, 0, 0, 0), 0);
      send(cmd_item(CMD_SETPRI, 0, 1, 0, 0), 0);
      send(cmd_item(CMD_CREATE, 63, 127, 7, 32'hffffffff), 0);
      send(cmd_item(CMD_WSTATE, 0, 0, ST_RUNNABLE, 0), 0);
      send(cmd_item(CMD_WSTATE, 0, 0, 7, 0), 0);
      send(cmd_item(CMD_WLEVEL, 0, -128, 0, 0), 0);
      send(cmd_item(CMD_WLEVEL, 0, 3, 0, 0), 0);
      r = cmd_item(CMD_SETPRI, 0, -2, 0, 0);
      r.target_pid = 1;
      send(r, 0);
      r.value = 4;
      send(r, 0);
      r.value = 2;
      send(r, 0);
      send(cmd_item(CMD_MLFQ, 0, 0, 0, 0), 0);
      send(cmd_item(CMD_MLFQ, 0, 0, 0, 0), 0);
      send(cmd_item(CMD_WLEVEL, 0, 2, 0, 32'hffffffff), 0);
      send(cmd_item(CMD_PICK, 0, 0, 0, 0), 0);
      send(cmd_item(CMD_BOOST, 0, 0, 0, 32'h80000000), 1);
      send(cmd_item(CMD_FCFS, 0, 0, 0, 0), 1);
      for (int i = 0; i < 64; i++) send(cmd_item(CMD_CREATE, 0, 0, 0, i), 1);
      send(cmd_item(CMD_WSTATE, 5, 0, ST_UNUSED, 0), 0);

      // random traffic
      for (int i = 0; i < RANDOM_ITEMS; i++) send(random_item(), $urandom_range(0, 4) == 0);
      req_ch.valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("ran %0d commands, %0d results checked, %0d mismatches",
               issued, rsp_seen, fail_count);
      if (fail_count == 0 && pending == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
rtl/fmps_pkg.sv
rtl/fmps_if.sv
rtl/fmps_beats.sv
rtl/fcfs_mlfq_process_selector.sv
tb/sv/fcfs_mlfq_process_selector_chk.sv
tb/sv/fcfs_mlfq_process_selector_tb.sv
